// ----- src/oand_pkg.sv -----
// shared types, constants and tables for the adpcm nibble decoder
`timescale 1ns / 1ps
package oand_pkg;

   localparam int STEP_COUNT = 49;
   localparam int IDX_W      = 6;
   localparam int STEP_W     = 11;
   localparam int PRED_W     = 18;
   localparam int GAIN_W     = 14;
   localparam int SAMPLE_W   = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [IDX_W-1:0] STEP_MAX = IDX_W'(STEP_COUNT - 1);

   localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd5948;
   localparam logic [7:0]        LEAK_MUL   = 8'd245;

   // ceil(2^25 / 3), exact floor(x / 3) for x below 2^25
   localparam logic [23:0] RECIP3   = 24'd11184811;
   localparam int          RECIP3_SH = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_RATIO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_CLOCK  = 3'd4;

   localparam logic [1:0] PAN_BOTH  = 2'd0;
   localparam logic [1:0] PAN_LEFT  = 2'd1;
   localparam logic [1:0] PAN_RIGHT = 2'd2;

   localparam logic [1:0] RATIO_CLAMP = 2'd2;

   localparam logic [STEP_W-1:0] STEP_ROM [STEP_COUNT] = '{
      11'd16,   11'd17,   11'd19,   11'd21,   11'd23,   11'd25,   11'd28,
      11'd31,   11'd34,   11'd37,   11'd41,   11'd45,   11'd50,   11'd55,
      11'd60,   11'd66,   11'd73,   11'd80,   11'd88,   11'd97,   11'd107,
      11'd118,  11'd130,  11'd143,  11'd157,  11'd173,  11'd190,  11'd209,
      11'd230,  11'd253,  11'd279,  11'd307,  11'd337,  11'd371,  11'd408,
      11'd449,  11'd494,  11'd544,  11'd598,  11'd658,  11'd724,  11'd796,
      11'd876,  11'd963,  11'd1060, 11'd1166, 11'd1282, 11'd1411, 11'd1552
   };

   localparam logic signed [4:0] INDEX_MOVE [8] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

   typedef struct packed {
      logic                    enable;
      logic [GAIN_W-1:0]       volume_gain;
      logic [1:0]              pan_mode;
      logic [1:0]              rate_ratio;
      logic                    slow_clock;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic mul1;
      logic calc_next;
      logic mul2;
      logic calc_delta;
      logic div;
      logic fix;
      logic emit;
      logic nib;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic run_end;
   } status_type;

endpackage

// ----- src/oand_channels.sv -----
// request, response and register write channels of the adpcm nibble decoder
`timescale 1ns / 1ps
interface oand_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] adpcm_byte;
   logic       data_valid;
   modport source (output valid, output adpcm_byte, output data_valid, input ready);
   modport sink   (input valid, input adpcm_byte, input data_valid, output ready);
endinterface

interface oand_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [oand_pkg::SAMPLE_W-1:0]    left_sample;
   logic signed [oand_pkg::SAMPLE_W-1:0]    right_sample;
   logic                                    last_of_run;
   modport source (output valid, output left_sample, output right_sample,
                   output last_of_run, input ready);
   modport sink   (input valid, input left_sample, input right_sample,
                   input last_of_run, output ready);
endinterface

interface oand_csr_if;
   logic                               valid;
   logic                               ready;
   logic [oand_pkg::CSR_IDX_W-1:0]     index;
   logic [oand_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/oki_adpcm_nibble_decoder_top.sv -----
// top level of the adpcm nibble decoder
`timescale 1ns / 1ps
// Decodes one ADPCM byte per request, low nibble first, and returns a run of
// n interpolated stereo pairs per nibble (n = 4 - rate_ratio, doubled by
// slow_clock; rate_ratio 3 acts as 2), last_of_run marking the final pair of
// the byte. A request is taken only while the decoder is idle; each nibble
// passes through six sequencer steps (step lookup and leak multiply,
// predictor update, gain multiply, interpolation delta, two divide steps)
// and then emits one pair per cycle while the response side does not stall.
// With enable low a request is still taken and produces nothing.
// Register writes are accepted at any time but must only be issued while
// the decoder is idle.
module oki_adpcm_nibble_decoder_top (
   input logic          clock,
   input logic          reset,
   oand_req_if.sink     req_if,
   oand_rsp_if.source   rsp_if,
   oand_csr_if.sink     csr_if
);

   oand_pkg::cfg_type    cfg;
   oand_pkg::cmd_type    cmd;
   oand_pkg::status_type status;

   oand_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_if.valid),
      .csr_ready (csr_if.ready),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .cfg       (cfg)
   );

   oand_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .enable    (cfg.enable),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   oand_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_adpcm_byte   (req_if.adpcm_byte),
      .req_data_valid   (req_if.data_valid),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_left_sample  (rsp_if.left_sample),
      .rsp_right_sample (rsp_if.right_sample),
      .rsp_last_of_run  (rsp_if.last_of_run)
   );

endmodule

// ----- src/oand_csr.sv -----
// configuration registers of the adpcm nibble decoder
`timescale 1ns / 1ps
module oand_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [oand_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [oand_pkg::CSR_DATA_W-1:0]    csr_data,
   output oand_pkg::cfg_type                  cfg
);

   oand_pkg::cfg_type cfg_ff;
   oand_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            oand_pkg::CSR_ENABLE:      cfg_in.enable      = csr_data[0];
            oand_pkg::CSR_VOLUME_GAIN: cfg_in.volume_gain = csr_data[oand_pkg::GAIN_W-1:0];
            oand_pkg::CSR_PAN_MODE:    cfg_in.pan_mode    = csr_data[1:0];
            oand_pkg::CSR_RATE_RATIO:  cfg_in.rate_ratio  = csr_data[1:0];
            oand_pkg::CSR_SLOW_CLOCK:  cfg_in.slow_clock  = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable      <= 1'b0;
         cfg_ff.volume_gain <= oand_pkg::GAIN_RESET;
         cfg_ff.pan_mode    <= oand_pkg::PAN_BOTH;
         cfg_ff.rate_ratio  <= 2'd0;
         cfg_ff.slow_clock  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/oand_ctrl.sv -----
// sequencer that walks each nibble through the decode datapath
`timescale 1ns / 1ps
module oand_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  oand_pkg::status_type  status,
   output oand_pkg::cmd_type     cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL1  = 8'b0000_0010,
      ST_NEXT  = 8'b0000_0100,
      ST_MUL2  = 8'b0000_1000,
      ST_DELTA = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_FIX   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      nib_ff, nib_in;
   logic      req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cmd            = '0;
      cmd.nib        = nib_ff;
      cmd.capture    = req_take && enable;
      cmd.mul1       = (state_ff == ST_MUL1);
      cmd.calc_next  = (state_ff == ST_NEXT);
      cmd.mul2       = (state_ff == ST_MUL2);
      cmd.calc_delta = (state_ff == ST_DELTA);
      cmd.div        = (state_ff == ST_DIV);
      cmd.fix        = (state_ff == ST_FIX);
      cmd.emit       = (state_ff == ST_EMIT) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      nib_in   = nib_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && enable) begin
               state_in = ST_MUL1;
               nib_in   = 1'b0;
            end
         end
         ST_MUL1:  state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_DELTA;
         ST_DELTA: state_in = ST_DIV;
         ST_DIV:   state_in = ST_FIX;
         ST_FIX:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free && status.run_end) begin
               if (nib_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MUL1;
                  nib_in   = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nib_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         nib_ff   <= nib_in;
      end
   end

   // a request taken while disabled leaves the sequencer idle
   a_disabled_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && !enable) |=> (state_ff == ST_IDLE))
      else $error("disabled request started a decode");

   // the low nibble's run hands over to the high nibble
   a_low_to_high: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.out_free && status.run_end && !nib_ff)
      |=> (state_ff == ST_MUL1 && nib_ff))
      else $error("high nibble not started after low nibble run");

endmodule

// ----- src/oand_dpath.sv -----
// decode datapath: step table, leaky predictor, gain, interpolation and output register
`timescale 1ns / 1ps
module oand_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  oand_pkg::cfg_type                     cfg,
   input  oand_pkg::cmd_type                     cmd,
   output oand_pkg::status_type                  status,
   input  logic [7:0]                            req_adpcm_byte,
   input  logic                                  req_data_valid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [oand_pkg::SAMPLE_W-1:0]  rsp_left_sample,
   output logic signed [oand_pkg::SAMPLE_W-1:0]  rsp_right_sample,
   output logic                                  rsp_last_of_run
);

   localparam int PW = oand_pkg::PRED_W;
   localparam int SW = oand_pkg::SAMPLE_W;
   localparam int DW = SW + 1;
   localparam int MW = 2 * DW;
   localparam logic signed [PW-1:0] PRED_HI = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] PRED_LO = {1'b1, {(PW-1){1'b0}}};

   // request capture
   logic [7:0] byte_ff;
   logic       dvalid_ff;

   // decode state
   logic [oand_pkg::IDX_W-1:0] step_index_ff, step_index_in;
   logic signed [PW-1:0]       pred_ff, pred_in;

   // stage registers
   logic signed [12:0]    diff_ff;
   logic signed [25:0]    pm245_ff;
   logic signed [31:0]    bprod_ff;
   logic signed [PW-1:0]  next_ff;
   logic signed [SW-1:0]  base_ff;
   logic signed [31:0]    tprod_ff;
   logic                  silent_ff;
   logic                  neg_ff;
   logic [DW-1:0]         mag_ff;
   logic [MW-1:0]         prod3_ff;
   logic signed [DW-1:0]  q0_ff;
   logic signed [4:0]     r0_ff;
   logic signed [DW-1:0]  acc_q_ff;
   logic signed [4:0]     acc_r_ff;
   logic [3:0]            k_ff;

   // output register
   logic                  out_valid_ff;
   logic signed [SW-1:0]  left_ff, right_ff;
   logic                  last_ff;

   logic [3:0]                 code;
   logic [oand_pkg::IDX_W-1:0] idx_c;
   logic [oand_pkg::STEP_W-1:0] step_c;
   logic [11:0]                dmag;
   logic signed [12:0]         diff_c;
   logic signed [6:0]          nidx_c;
   logic signed [PW:0]         sum_c;
   logic signed [PW-1:0]       next_c;
   logic signed [PW-1:0]       dec_c;
   logic signed [31:0]         gain_s;
   logic signed [SW-1:0]       target_c;
   logic signed [DW-1:0]       delta_c;
   logic [1:0]                 ratio_c;
   logic [3:0]                 n_c;
   logic [DW-1:0]              mag3_c;
   logic [DW-1:0]              q_c;
   logic [DW-1:0]              r_full;
   logic signed [4:0]          n5;
   logic signed [DW-1:0]       qs;
   logic signed [4:0]          rs;
   logic signed [DW-1:0]       v_c;
   logic signed [SW-1:0]       samp_c;

   assign gain_s = $signed({{(32 - oand_pkg::GAIN_W){1'b0}}, cfg.volume_gain});

   // run length per nibble
   always_comb begin
      ratio_c = (cfg.rate_ratio == 2'd3) ? oand_pkg::RATIO_CLAMP : cfg.rate_ratio;
      n_c     = 4'd4 - {2'b00, ratio_c};
      if (cfg.slow_clock) begin
         n_c = {n_c[2:0], 1'b0};
      end
   end

   // step lookup and index update
   always_comb begin
      code   = cmd.nib ? byte_ff[7:4] : byte_ff[3:0];
      idx_c  = (step_index_ff > oand_pkg::STEP_MAX) ? oand_pkg::STEP_MAX : step_index_ff;
      step_c = oand_pkg::STEP_ROM[idx_c];
      dmag   = 12'(step_c >> 3)
             + (code[0] ? 12'(step_c >> 2) : 12'd0)
             + (code[1] ? 12'(step_c >> 1) : 12'd0)
             + (code[2] ? 12'(step_c)      : 12'd0);
      diff_c = code[3] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
      nidx_c = $signed({1'b0, idx_c}) + 7'(oand_pkg::INDEX_MOVE[code[2:0]]);
      if (nidx_c < 0) begin
         step_index_in = '0;
      end else if (nidx_c > $signed({1'b0, oand_pkg::STEP_MAX})) begin
         step_index_in = oand_pkg::STEP_MAX;
      end else begin
         step_index_in = nidx_c[oand_pkg::IDX_W-1:0];
      end
   end

   // leaky predictor with saturation, then decay when data is missing
   always_comb begin
      sum_c = (PW+1)'(diff_ff) + (PW+1)'(pm245_ff >>> 8);
      if (sum_c > (PW+1)'(PRED_HI)) begin
         next_c = PRED_HI;
      end else if (sum_c < (PW+1)'(PRED_LO)) begin
         next_c = PRED_LO;
      end else begin
         next_c = sum_c[PW-1:0];
      end
      dec_c = next_ff;
      if (!dvalid_ff) begin
         if (next_ff < 0) begin
            dec_c = next_ff + PW'(1);
         end else if (next_ff > 0) begin
            dec_c = next_ff - PW'(1);
         end
      end
      pred_in = dec_c;
   end

   always_comb begin
      target_c = silent_ff ? '0 : SW'(tprod_ff >>> 9);
      delta_c  = DW'(target_c) - DW'(base_ff);
   end

   // quotient and remainder of |delta| / n
   always_comb begin
      mag3_c = (n_c == 4'd6) ? (mag_ff >> 1) : mag_ff;
      case (n_c)
         4'd2:    q_c = mag_ff >> 1;
         4'd4:    q_c = mag_ff >> 2;
         4'd8:    q_c = mag_ff >> 3;
         default: q_c = DW'(prod3_ff >> oand_pkg::RECIP3_SH);
      endcase
      r_full = mag_ff - DW'(q_c * {{(DW-4){1'b0}}, n_c});
   end

   // running quotient/remainder of delta*k/n, truncated toward zero
   always_comb begin
      n5 = $signed({1'b0, n_c});
      qs = acc_q_ff + q0_ff;
      rs = acc_r_ff + r0_ff;
      if (!neg_ff && rs >= n5) begin
         qs = qs + DW'(1);
         rs = rs - n5;
      end else if (neg_ff && rs <= -n5) begin
         qs = qs - DW'(1);
         rs = rs + n5;
      end
      v_c    = DW'(base_ff) + qs;
      samp_c = v_c[SW-1:0];
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.run_end  = (k_ff == (n_c - 4'd1));

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_sample  = left_ff;
   assign rsp_right_sample = right_ff;
   assign rsp_last_of_run  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff <= '0;
         pred_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.mul1) begin
            step_index_ff <= step_index_in;
         end
         if (cmd.mul2) begin
            pred_ff <= pred_in;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff   <= req_adpcm_byte;
         dvalid_ff <= req_data_valid;
      end
      if (cmd.mul1) begin
         diff_ff  <= diff_c;
         pm245_ff <= 26'(pred_ff) * $signed({18'd0, oand_pkg::LEAK_MUL});
         bprod_ff <= 32'(pred_ff) * gain_s;
      end
      if (cmd.calc_next) begin
         next_ff <= next_c;
         base_ff <= SW'(bprod_ff >>> 9);
      end
      if (cmd.mul2) begin
         tprod_ff  <= 32'(next_ff) * gain_s;
         silent_ff <= (pred_in >= -PW'(1)) && (pred_in <= PW'(1));
      end
      if (cmd.calc_delta) begin
         neg_ff <= delta_c < 0;
         mag_ff <= (delta_c < 0) ? DW'(-delta_c) : DW'(delta_c);
      end
      if (cmd.div) begin
         prod3_ff <= MW'(mag3_c) * MW'(oand_pkg::RECIP3);
      end
      if (cmd.fix) begin
         q0_ff    <= neg_ff ? -$signed(q_c) : $signed(q_c);
         r0_ff    <= neg_ff ? -$signed({1'b0, r_full[3:0]}) : $signed({1'b0, r_full[3:0]});
         acc_q_ff <= '0;
         acc_r_ff <= '0;
         k_ff     <= '0;
      end
      if (cmd.emit) begin
         acc_q_ff <= qs;
         acc_r_ff <= rs;
         k_ff     <= k_ff + 4'd1;
         left_ff  <= (cfg.pan_mode == oand_pkg::PAN_BOTH || cfg.pan_mode == oand_pkg::PAN_LEFT)
                     ? samp_c : '0;
         right_ff <= (cfg.pan_mode == oand_pkg::PAN_BOTH || cfg.pan_mode == oand_pkg::PAN_RIGHT)
                     ? samp_c : '0;
         last_ff  <= cmd.nib && status.run_end;
      end
   end

   // step index never leaves the table
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      step_index_ff <= oand_pkg::STEP_MAX)
      else $error("step index beyond table");

   // interpolation remainder stays below the run length
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (acc_r_ff < $signed({1'b0, n_c}) && acc_r_ff > -$signed({1'b0, n_c})))
      else $error("interpolation remainder out of range");

endmodule
